/* rtl/kpd_pkg.sv */
// shared types and constants for the keypad debounce and autorepeat block
package kpd_pkg;

    localparam int MATRIX_W = 16;
    localparam int KEY_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [MATRIX_W-1:0] t_matrix;
    typedef logic [KEY_W-1:0]    t_key;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = 8'd10;
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST = 8'd1;

    typedef struct packed {
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] repeat_ticks;
    } t_cfg;

endpackage

/* rtl/kpd_encode.sv */
// priority encoder from the 4x4 key matrix to a row/column one-hot code
module kpd_encode (
    input  kpd_pkg::t_matrix i_matrix,
    output kpd_pkg::t_key    o_key
);
    import kpd_pkg::*;

    t_key key;

    // scan from the lowest bit up so the bottom row, rightmost column wins
    always_comb begin
        key = '0;
        for (int b = 0; b < MATRIX_W; b++) begin
            if (i_matrix[b]) begin
                key = '0;
                key[4 + b/4] = 1'b1;
                key[b%4]     = 1'b1;
            end
        end
    end

    assign o_key = key;

endmodule

/* rtl/kpd_qualify.sv */
// four-phase debounce and autorepeat qualifier
module kpd_qualify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  kpd_pkg::t_key i_key,
    input  kpd_pkg::t_cfg i_cfg,
    output kpd_pkg::t_key o_emit
);
    import kpd_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_CANDIDATE = 2'd1;
    localparam logic [1:0] PH_CONFIRMED = 2'd2;
    localparam logic [1:0] PH_REPEAT    = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [CFG_W-1:0] r_count, n_count;
    t_key             r_last,  n_last;
    t_key             emit;
    logic [CFG_W-1:0] count_inc;
    logic             same;

    assign count_inc = r_count + 1'b1;
    assign same      = (i_key == r_last);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_last  = r_last;
        emit    = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_key != '0) begin
                    n_last  = i_key;
                    n_phase = PH_CANDIDATE;
                end
            end
            PH_CANDIDATE: begin
                if (same) begin
                    n_phase = PH_CONFIRMED;
                    n_count = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CONFIRMED: begin
                if (!same) begin
                    n_phase = PH_IDLE;
                    emit    = r_last;
                end else if (count_inc >= i_cfg.hold_ticks) begin
                    n_phase = PH_REPEAT;
                    n_count = '0;
                    emit    = r_last;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_REPEAT: begin
                if (!same) begin
                    n_phase = PH_IDLE;
                end else if (count_inc >= i_cfg.repeat_ticks) begin
                    n_count = '0;
                    emit    = r_last;
                end else begin
                    n_count = count_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_last  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    assign o_emit = emit;

endmodule

/* rtl/keypad_debounce_autorepeat.sv */
// top level: keypad scan debounce with hold and autorepeat emit
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_key_matrix (16 bit snapshot)
// output    out        o_valid / i_ready    o_key_code   (8 bit, 0 = no key)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one word per clock in steady state while the output is not stalled; a word
// taken into the input register moves to the result register when that is free
// or draining, so o_valid rises with that move; encode and phase update lie in between
// every scan word yields exactly one result word, zero when nothing is emitted
// reset (synchronous, active low) clears phase, counter, key and both valids,
// and loads hold_ticks = 10, repeat_ticks = 1
// a stalled output holds its word while the input register still takes one
module keypad_debounce_autorepeat (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // scan input
    input  logic                               i_valid,
    output logic                               o_ready,
    input  kpd_pkg::t_matrix                   i_key_matrix,
    // qualified key output
    output logic                               o_valid,
    input  logic                               i_ready,
    output kpd_pkg::t_key                      o_key_code,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kpd_pkg::CFG_W-1:0]          i_cfg_data
);
    import kpd_pkg::*;

    // configuration registers
    t_cfg    r_cfg;

    // input register
    logic    r_in_valid;
    t_matrix r_matrix;

    // result register
    logic    r_out_valid;
    t_key    r_key_code;

    logic    advance;
    t_key    enc_key;
    t_key    emit;

    // the stored word moves on when the result register is free or draining
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks   <= HOLD_TICKS_RST;
            r_cfg.repeat_ticks <= REPEAT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOLD_TICKS:   r_cfg.hold_ticks   <= i_cfg_data;
                REG_REPEAT_TICKS: r_cfg.repeat_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage: capture the scan word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_matrix <= i_key_matrix;
        end
    end

    kpd_encode u_encode (
        .i_matrix (r_matrix),
        .o_key    (enc_key)
    );

    // phase state only moves when a word goes to the result register
    kpd_qualify u_qualify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_key     (enc_key),
        .i_cfg     (r_cfg),
        .o_emit    (emit)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_key_code <= emit;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_code = r_key_code;

endmodule

/* test/keypad_debounce_autorepeat_test.sv */
// testbench for the keypad debounce and autorepeat block with a key qualifier model
`timescale 1ns / 1ps

module keypad_debounce_autorepeat_test;
    import kpd_pkg::*;

    // qualifier phases, same meaning as in the block
    typedef enum logic [1:0] {
        QS_IDLE,
        QS_CAND,
        QS_CONFIRMED,
        QS_REPEAT
    } t_qual_phase;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_EVERY_THIRD,
        RX_RANDOM,
        RX_LONG
    } t_rx_mode;

    localparam int  CLK_HALF  = 4;
    localparam int  RST_TICKS = 10;
    localparam int  MAX_PRESS = 60;

    // every input of the block starts at a known value
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic                   o_ready;
    t_matrix                i_key_matrix = '0;
    logic                   o_valid;
    logic                   i_ready      = 1'b0;
    t_key                   o_key_code;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx    = REG_HOLD_TICKS;
    logic [CFG_W-1:0]       i_cfg_data   = '0;

    // scan words waiting for the driver, key codes waiting for the monitor
    t_matrix     scan_words[$];
    t_key        key_expect[$];

    // qualifier model state and its copy of the registers
    t_qual_phase kp_phase   = QS_IDLE;
    logic [7:0]  kp_count   = '0;
    t_key        kp_last    = '0;
    logic [7:0]  cfg_hold   = HOLD_TICKS_RST;
    logic [7:0]  cfg_repeat = REPEAT_TICKS_RST;

    // sender burst shaping
    int          burst_left = 1;
    int          gap_left   = 0;

    // receiver stall shaping
    t_rx_mode    stall_mode = RX_OPEN;
    int          mode_left  = 0;
    int          stall_left = 0;
    int          stall_tick = 0;

    int          errors        = 0;
    int          words_made    = 0;
    int          words_checked = 0;
    int          codes_seen    = 0;
    int          settings_run  = 0;

    keypad_debounce_autorepeat i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_matrix (i_key_matrix),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_code   (o_key_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // generous bound on the whole run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // pick the closed key of highest priority: bottom row, then rightmost column
    function automatic t_key priority_key(input t_matrix m);
        int r;
        int c;
        for (r = 3; r >= 0; r--) begin
            for (c = 3; c >= 0; c--) begin
                if (m[r*4 + c])
                    return t_key'((8'h10 << r) | (8'h01 << c));
            end
        end
        return '0;
    endfunction

    // advance the qualifier by one scan tick and return the code it emits
    function automatic t_key qualify_scan(input t_matrix m);
        t_key k;
        t_key emit;
        k    = priority_key(m);
        emit = '0;
        case (kp_phase)
            QS_IDLE: begin
                if (k != '0) begin
                    kp_last  = k;
                    kp_phase = QS_CAND;
                end
            end
            QS_CAND: begin
                if (k == kp_last) begin
                    kp_phase = QS_CONFIRMED;
                    kp_count = '0;
                end else begin
                    kp_phase = QS_IDLE;
                end
            end
            QS_CONFIRMED: begin
                // release or change emits the held key once
                if (k != kp_last) begin
                    kp_phase = QS_IDLE;
                    emit     = kp_last;
                end else begin
                    kp_count = kp_count + 8'd1;
                    if (kp_count >= cfg_hold) begin
                        kp_phase = QS_REPEAT;
                        kp_count = '0;
                        emit     = kp_last;
                    end
                end
            end
            default: begin
                // leaving autorepeat is silent
                if (k != kp_last) begin
                    kp_phase = QS_IDLE;
                end else begin
                    kp_count = kp_count + 8'd1;
                    if (kp_count >= cfg_repeat) begin
                        kp_count = '0;
                        emit     = kp_last;
                    end
                end
            end
        endcase
        return emit;
    endfunction

    // driver: bursts of random length, random gaps, valid held until taken
    always @(posedge i_clk) begin
        bit load;
        load = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // an accepted scan word is predicted at the edge that takes it
            if (i_valid && o_ready)
                key_expect.push_back(qualify_scan(i_key_matrix));
            // the slot is free unless a word is still waiting for ready
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (scan_words.size() > 0) begin
                    load = 1'b1;
                    i_key_matrix <= scan_words.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        // a zero gap often, so bursts run back to back
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                i_valid <= load;
            end
        end
    end

    // monitor: checks each taken word against the oldest predicted code
    always @(posedge i_clk) begin
        t_key exp_code;
        bit   rdy;
        rdy = 1'b1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (key_expect.size() == 0) begin
                    $error("unexpected word: key_code actual %h", o_key_code);
                    errors++;
                end else begin
                    exp_code = key_expect.pop_front();
                    words_checked++;
                    if (exp_code != '0)
                        codes_seen++;
                    if (o_key_code !== exp_code) begin
                        $error("key_code mismatch: expected %h, actual %h",
                               exp_code, o_key_code);
                        errors++;
                    end
                end
            end
            // switch stall pattern when mode_left runs out
            if (mode_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                RX_OPEN:        rdy = 1'b1;
                RX_EVERY_THIRD: begin
                    stall_tick++;
                    rdy = (stall_tick % 3) != 0;
                end
                RX_RANDOM:      rdy = $urandom_range(0, 3) != 0;
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
            i_ready <= rdy;
        end
    end

    function automatic void push_scan(input t_matrix w);
        scan_words.push_back(w);
        words_made++;
    endfunction

    // hold key b for len ticks, sometimes with lower priority keys closed too
    function automatic void press_key(input int b, input int len);
        t_matrix w;
        t_matrix lower;
        int      i;
        lower = (t_matrix'(1) << b) - t_matrix'(1);
        for (i = 0; i < len; i++) begin
            w = t_matrix'(1) << b;
            if ($urandom_range(0, 2) == 0)
                w = w | (t_matrix'($urandom) & lower);
            push_scan(w);
        end
    endfunction

    // random scan words: mostly clean presses, some bounce, noise and idle
    function automatic void fill_random(input int budget);
        int target;
        int hold_eff;
        int rep_eff;
        int top;
        int len;
        int b;
        int n;
        target   = words_made + budget;
        hold_eff = (cfg_hold == 0) ? 1 : cfg_hold;
        rep_eff  = (cfg_repeat == 0) ? 1 : cfg_repeat;
        top      = hold_eff + 3 * rep_eff + 3;
        if (top > MAX_PRESS)
            top = MAX_PRESS;
        while (words_made < target) begin
            b = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    case ($urandom_range(0, 3))
                        0:       len = $urandom_range(1, 3);
                        // land on either side of the first emit
                        1:       len = hold_eff + $urandom_range(1, 3);
                        default: len = $urandom_range(1, top);
                    endcase
                    if (len > MAX_PRESS)
                        len = MAX_PRESS;
                    press_key(b, len);
                    // no release sometimes, so the key changes directly
                    repeat ($urandom_range(0, 2)) push_scan('0);
                end
                6: begin
                    // contact bounce
                    repeat ($urandom_range(1, 4)) begin
                        press_key(b, 1);
                        if ($urandom_range(0, 1) == 0)
                            push_scan('0);
                        else
                            push_scan(t_matrix'(1) << $urandom_range(0, 15));
                    end
                end
                7, 8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_scan(t_matrix'($urandom_range(0, 16'hFFFF)));
                end
                default: repeat ($urandom_range(1, 3)) push_scan('0);
            endcase
        end
    endfunction

    // wait until every queued word is taken and every code checked
    task automatic drain_all();
        do
            @(negedge i_clk);
        while (scan_words.size() != 0 || i_valid || key_expect.size() != 0);
        // latency margin before the block is touched again
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_HOLD_TICKS)
            cfg_hold = val;
        else
            cfg_repeat = val;
    endtask

    task automatic set_regs(input logic [7:0] hold, input logic [7:0] rpt);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_REPEAT_TICKS, rpt);
        settings_run++;
    endtask

    initial begin
        repeat (RST_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset values: hold 10, repeat 1
        settings_run++;
        push_scan(16'h0000);
        // all keys closed: bottom right wins, held into autorepeat
        repeat (13) push_scan(16'hFFFF);
        // release from autorepeat, silent
        push_scan(16'h0000);
        // top left confirmed, emitted on release
        push_scan(16'h0001);
        push_scan(16'h0001);
        push_scan(16'h0000);
        // same key under a changing matrix, then a change emits it
        push_scan(16'h0F0F);
        push_scan(16'h0808);
        push_scan(16'h0400);
        // candidate dropped on a different key
        push_scan(16'h0010);
        push_scan(16'h0020);
        push_scan(16'h0000);
        drain_all();

        set_regs(8'd1, 8'd1);
        fill_random(30);
        drain_all();

        // zero registers behave like one
        set_regs(8'd0, 8'd0);
        fill_random(25);
        drain_all();

        set_regs(8'd3, 8'd2);
        fill_random(40);
        drain_all();

        // top of range: one hold all the way through the first repeat emit
        set_regs(8'd255, 8'd255);
        press_key($urandom_range(0, 15), 2 + 255 + 255 + 2);
        push_scan('0);
        fill_random(10);
        drain_all();

        set_regs(8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)));
        fill_random(30);
        drain_all();

        set_regs(8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)));
        fill_random(30);
        drain_all();

        // back to the reset values
        set_regs(HOLD_TICKS_RST, REPEAT_TICKS_RST);
        fill_random(25);
        drain_all();

        repeat (8) @(posedge i_clk);
        $display("run covered %0d scan words under %0d register settings", words_checked,
                 settings_run);
        $display("%0d key codes were emitted and matched", codes_seen);
        if (errors == 0 && key_expect.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/kpd_pkg.sv
rtl/kpd_encode.sv
rtl/kpd_qualify.sv
rtl/keypad_debounce_autorepeat.sv
test/keypad_debounce_autorepeat_test.sv
